// ===== rtl/esc_reverse_arming_drive_sequencer_unit_assert.svh =====
// Assertion macros used by the drive sequencer top level.
`ifndef ESC_REVERSE_ARMING_DRIVE_SEQUENCER_UNIT_ASSERT_SVH
`define ESC_REVERSE_ARMING_DRIVE_SEQUENCER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define ERADS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define ERADS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/esc_rads_pkg.sv =====
// Types and constants for the reverse-arming drive sequencer.
`default_nettype none

package esc_rads_pkg;

  localparam int unsigned TIMER_W = 12;
  localparam int unsigned US_W    = 11;
  localparam int unsigned MODE_W  = 3;

  // Input opcodes carried on s_axis_tuser
  localparam logic OP_PACKET = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Drive modes
  localparam logic [MODE_W-1:0] MODE_NEUTRAL   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FORWARD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ARM_BRAKE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ARM_PAUSE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REVERSE   = 3'd4;
  localparam logic [MODE_W-1:0] MODE_PRE_BRAKE = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PRE_PAUSE = 3'd6;

  // Register indexes
  localparam logic [2:0] REG_REVERSE_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_IDLE_LIMIT_MS     = 3'd1;
  localparam logic [2:0] REG_ARM_BRAKE_MS      = 3'd2;
  localparam logic [2:0] REG_ARM_PAUSE_MS      = 3'd3;
  localparam logic [2:0] REG_BRAKE_PULSE_US    = 3'd4;
  localparam logic [2:0] REG_REVERSE_PULSE_US  = 3'd5;
  localparam logic [2:0] REG_SERVO_MIN_US      = 3'd6;
  localparam logic [2:0] REG_SERVO_MAX_US      = 3'd7;

  // Pulse widths and timing
  localparam logic [US_W-1:0]    NEUTRAL_US      = 11'd1500;
  localparam logic [US_W-1:0]    ESC_MIN_US      = 11'd1000;
  localparam logic [US_W-1:0]    ESC_MAX_US      = 11'd2000;
  localparam logic [TIMER_W-1:0] TIMER_MAX       = 12'd4095;
  localparam logic [TIMER_W-1:0] PRE_BRAKE_TICKS = 12'd200;
  localparam logic [TIMER_W-1:0] PRE_PAUSE_TICKS = 12'd100;

  typedef struct packed {
    logic [7:0]         reverse_threshold;
    logic [TIMER_W-1:0] idle_limit_ms;
    logic [TIMER_W-1:0] arm_brake_ms;
    logic [TIMER_W-1:0] arm_pause_ms;
    logic [US_W-1:0]    brake_pulse_us;
    logic [US_W-1:0]    reverse_pulse_us;
    logic [US_W-1:0]    servo_min_us;
    logic [US_W-1:0]    servo_max_us;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [TIMER_W-1:0] phase_timer;
    logic [TIMER_W-1:0] since_packet;
    logic               remote_active;
    logic [US_W-1:0]    servo_width;
    logic [US_W-1:0]    esc_width;
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/esc_rads_cfg_regs.sv =====
// APB register bank holding the sequencer settings.
`default_nettype none

module esc_rads_cfg_regs
  import esc_rads_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reverse_threshold <= 8'd64;
      cfg_q.idle_limit_ms     <= 12'd500;
      cfg_q.arm_brake_ms      <= 12'd700;
      cfg_q.arm_pause_ms      <= 12'd300;
      cfg_q.brake_pulse_us    <= 11'd1460;
      cfg_q.reverse_pulse_us  <= 11'd1450;
      cfg_q.servo_min_us      <= 11'd1250;
      cfg_q.servo_max_us      <= 11'd1750;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_REVERSE_THRESHOLD: cfg_q.reverse_threshold <= pwdata[7:0];
        REG_IDLE_LIMIT_MS:     cfg_q.idle_limit_ms     <= pwdata[TIMER_W-1:0];
        REG_ARM_BRAKE_MS:      cfg_q.arm_brake_ms      <= pwdata[TIMER_W-1:0];
        REG_ARM_PAUSE_MS:      cfg_q.arm_pause_ms      <= pwdata[TIMER_W-1:0];
        REG_BRAKE_PULSE_US:    cfg_q.brake_pulse_us    <= pwdata[US_W-1:0];
        REG_REVERSE_PULSE_US:  cfg_q.reverse_pulse_us  <= pwdata[US_W-1:0];
        REG_SERVO_MIN_US:      cfg_q.servo_min_us      <= pwdata[US_W-1:0];
        REG_SERVO_MAX_US:      cfg_q.servo_max_us      <= pwdata[US_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_REVERSE_THRESHOLD: prdata = 32'(cfg_q.reverse_threshold);
      REG_IDLE_LIMIT_MS:     prdata = 32'(cfg_q.idle_limit_ms);
      REG_ARM_BRAKE_MS:      prdata = 32'(cfg_q.arm_brake_ms);
      REG_ARM_PAUSE_MS:      prdata = 32'(cfg_q.arm_pause_ms);
      REG_BRAKE_PULSE_US:    prdata = 32'(cfg_q.brake_pulse_us);
      REG_REVERSE_PULSE_US:  prdata = 32'(cfg_q.reverse_pulse_us);
      REG_SERVO_MIN_US:      prdata = 32'(cfg_q.servo_min_us);
      REG_SERVO_MAX_US:      prdata = 32'(cfg_q.servo_max_us);
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/esc_rads_update.sv =====
// Next-state logic: applies one packet or tick to the drive state.
`default_nettype none

module esc_rads_update
  import esc_rads_pkg::*;
(
  input  wire cfg_t        cfg_i,
  input  wire state_t      state_i,
  input  wire logic        opcode_i,
  input  wire logic [7:0]  steer_i,
  input  wire logic [7:0]  throttle_i,
  output state_t           state_o
);

  // floor(s*738/255) == (s * 12138870) >> 22 for every 8-bit s
  localparam logic [23:0]     STEER_RECIP   = 24'd12138870;
  localparam int unsigned     STEER_SHIFT   = 22;
  localparam logic [US_W-1:0] SERVO_BASE_US = 11'd1142;
  localparam logic [7:0]      THR_FWD_MIN   = 8'd127;
  localparam logic [15:0]     FWD_GAIN      = 16'd500;
  localparam logic [US_W-1:0] FWD_DEADBAND  = 11'd1505;

  function automatic logic [US_W-1:0] clamp_esc(input logic [US_W-1:0] v);
    if (v < ESC_MIN_US) begin
      return ESC_MIN_US;
    end else if (v > ESC_MAX_US) begin
      return ESC_MAX_US;
    end
    return v;
  endfunction

  // Lower limit is tested first; a raised value is not checked again.
  function automatic logic [US_W-1:0] clamp_servo(input logic [US_W-1:0] v,
                                                  input logic [US_W-1:0] lo,
                                                  input logic [US_W-1:0] hi);
    if (v < lo) begin
      return lo;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  logic [31:0]        steer_prod;
  logic [US_W-1:0]    steer_us;
  logic [7:0]         thr_off;
  logic [15:0]        fwd_prod;
  logic [US_W-1:0]    fwd_us;
  logic [TIMER_W-1:0] phase_inc;
  logic [TIMER_W-1:0] since_inc;

  assign steer_prod = 32'(steer_i) * 32'(STEER_RECIP);
  assign steer_us   = SERVO_BASE_US + 11'(steer_prod[STEER_SHIFT+9:STEER_SHIFT]);
  assign thr_off    = throttle_i - THR_FWD_MIN;
  assign fwd_prod   = 16'(thr_off) * FWD_GAIN;
  assign fwd_us     = NEUTRAL_US + 11'(fwd_prod[15:7]);
  assign phase_inc  = (state_i.phase_timer < TIMER_MAX) ? state_i.phase_timer + 1'b1
                                                        : state_i.phase_timer;
  assign since_inc  = (state_i.since_packet < TIMER_MAX) ? state_i.since_packet + 1'b1
                                                         : state_i.since_packet;

  always_comb begin
    state_o = state_i;
    if (opcode_i == OP_PACKET) begin
      // Control packet: steering applied (centred in the neutral throttle band), throttle only outside arming
      state_o.servo_width   = clamp_servo(steer_us, cfg_i.servo_min_us,
                                          cfg_i.servo_max_us);
      state_o.since_packet  = '0;
      state_o.remote_active = 1'b1;
      case (state_i.mode) inside
        MODE_ARM_BRAKE, MODE_ARM_PAUSE, MODE_PRE_BRAKE, MODE_PRE_PAUSE: ;
        default: begin
          if (throttle_i < cfg_i.reverse_threshold) begin
            if (state_i.mode != MODE_REVERSE) begin
              state_o.esc_width   = clamp_esc(cfg_i.brake_pulse_us);
              state_o.mode        = (state_i.mode == MODE_FORWARD) ? MODE_PRE_BRAKE
                                                                   : MODE_ARM_BRAKE;
              state_o.phase_timer = '0;
            end
          end else if (throttle_i >= THR_FWD_MIN) begin
            state_o.mode      = (fwd_us > FWD_DEADBAND) ? MODE_FORWARD : MODE_NEUTRAL;
            state_o.esc_width = clamp_esc(fwd_us);
          end else begin
            state_o.esc_width   = NEUTRAL_US;
            state_o.servo_width = clamp_servo(NEUTRAL_US, cfg_i.servo_min_us,
                                              cfg_i.servo_max_us);
            state_o.mode        = MODE_NEUTRAL;
          end
        end
      endcase
    end else begin
      // Tick: advance timers, then let phase exits chain in order, then apply the idle timeout
      state_o.phase_timer  = phase_inc;
      state_o.since_packet = since_inc;
      if (state_o.mode == MODE_PRE_BRAKE && state_o.phase_timer >= PRE_BRAKE_TICKS) begin
        state_o.esc_width   = NEUTRAL_US;
        state_o.mode        = MODE_PRE_PAUSE;
        state_o.phase_timer = '0;
      end
      if (state_o.mode == MODE_PRE_PAUSE && state_o.phase_timer >= PRE_PAUSE_TICKS) begin
        state_o.esc_width   = clamp_esc(cfg_i.brake_pulse_us);
        state_o.mode        = MODE_ARM_BRAKE;
        state_o.phase_timer = '0;
      end
      if (state_o.mode == MODE_ARM_BRAKE && state_o.phase_timer >= cfg_i.arm_brake_ms) begin
        state_o.esc_width   = NEUTRAL_US;
        state_o.mode        = MODE_ARM_PAUSE;
        state_o.phase_timer = '0;
      end
      if (state_o.mode == MODE_ARM_PAUSE && state_o.phase_timer >= cfg_i.arm_pause_ms) begin
        state_o.esc_width   = clamp_esc(cfg_i.reverse_pulse_us);
        state_o.mode        = MODE_REVERSE;
        state_o.phase_timer = '0;
      end
      if (state_o.remote_active &&
          (state_o.mode == MODE_FORWARD || state_o.mode == MODE_REVERSE) &&
          state_o.since_packet > cfg_i.idle_limit_ms) begin
        state_o.esc_width   = NEUTRAL_US;
        state_o.servo_width = clamp_servo(NEUTRAL_US, cfg_i.servo_min_us,
                                          cfg_i.servo_max_us);
        state_o.mode        = MODE_NEUTRAL;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/esc_reverse_arming_drive_sequencer_unit.sv =====
// An accepted item passes through the input register, then the state/result register, to the master side.
// Throughput: one item per cycle while the master side takes results; the combinational state update sets the rate.
// On back-pressure the state/result register holds, and the input register holds once it is full.
// Reset (rst_ni low, asynchronous): mode neutral, timers cleared, both widths 1500 us,
// settings back to their defaults, both channels empty.
`default_nettype none
`include "esc_reverse_arming_drive_sequencer_unit_assert.svh"

// Top level of the reverse-arming drive sequencer.
module esc_reverse_arming_drive_sequencer_unit
  import esc_rads_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Item input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [7:0] steer, [15:8] throttle
  input  wire logic        s_axis_tuser,   // [0] opcode: 0 packet, 1 tick
  // Result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // [10:0] servo_pulse_us,
                                           // [21:11] esc_pulse_us,
                                           // [24:22] drive_mode, rest zero
  // Configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t   cfg;
  state_t state_q, state_d;

  // Input register
  logic       in_valid_q, in_valid_d;
  logic       in_opcode_q;
  logic [7:0] in_steer_q;
  logic [7:0] in_thr_q;

  // Result valid; the state register doubles as the result register
  logic out_valid_q, out_valid_d;

  logic s_accept;
  logic m_accept;
  logic advance;

  esc_rads_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  esc_rads_update u_update (
    .cfg_i      (cfg),
    .state_i    (state_q),
    .opcode_i   (in_opcode_q),
    .steer_i    (in_steer_q),
    .throttle_i (in_thr_q),
    .state_o    (state_d)
  );

  // Move the held item into the state when the result slot is free or being taken
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = m_axis_tvalid && m_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_accept) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload of the input register: no reset needed
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_opcode_q <= s_axis_tuser;
      in_steer_q  <= s_axis_tdata[7:0];
      in_thr_q    <= s_axis_tdata[15:8];
    end
  end

  // Drive state: updated once per item, held while the result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode          <= MODE_NEUTRAL;
      state_q.phase_timer   <= '0;
      state_q.since_packet  <= '0;
      state_q.remote_active <= 1'b0;
      state_q.servo_width   <= NEUTRAL_US;
      state_q.esc_width     <= NEUTRAL_US;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, state_q.mode, state_q.esc_width, state_q.servo_width};

  `ERADS_ASSERT(a_esc_range, state_q.esc_width >= ESC_MIN_US && state_q.esc_width <= ESC_MAX_US, "esc width out of range")
  `ERADS_ASSERT(a_mode_code, state_q.mode <= MODE_PRE_PAUSE, "drive mode code undefined")
  `ERADS_ASSERT_NEXT(a_advance_shows, advance, m_axis_tvalid, "result missing after update")
  `ERADS_ASSERT(a_stall_cause, !s_axis_tready || (in_valid_q == 1'b0) || advance, "input stalled without cause")
  `ERADS_ASSERT(a_stall_full, s_axis_tready || (in_valid_q && out_valid_q && !m_axis_tready), "input stalled while pipeline has room")

endmodule

`default_nettype wire
